/* hdl/ccfp_pkg.sv */
// Shared types, codes and the CRC-16 byte update for the command frame parser.
package ccfp_pkg;

  localparam int unsigned LEN_W  = 16;
  localparam int unsigned DIDX_W = 10;
  localparam int unsigned ST_W   = 3;

  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  localparam logic [LEN_W-1:0] MIN_LEN    = 16'd5;
  localparam logic [LEN_W-1:0] OVERHEAD   = 16'd9;
  localparam logic [LEN_W-1:0] CRC_BYTES  = 16'd2;
  localparam logic [LEN_W-1:0] POS_OPCODE = 16'd2;
  localparam logic [LEN_W-1:0] POS_P1     = 16'd3;
  localparam logic [LEN_W-1:0] POS_P2     = 16'd4;
  localparam logic [LEN_W-1:0] POS_P3_LO  = 16'd5;
  localparam logic [LEN_W-1:0] POS_P3_HI  = 16'd6;
  localparam logic [LEN_W-1:0] POS_DATA   = 16'd7;
  localparam logic [LEN_W-1:0] P3_MIN_LEN = 16'd9;

  localparam logic [7:0] TIMEOUT_RST = 8'd100;
  localparam logic [7:0] TICK_MAX    = 8'hFF;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic REG_START_BYTE = 1'b0;
  localparam logic REG_TIMEOUT    = 1'b1;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_SHORT   = 3'd1;
  localparam logic [ST_W-1:0] ST_LONG    = 3'd2;
  localparam logic [ST_W-1:0] ST_CRC_ERR = 3'd3;
  localparam logic [ST_W-1:0] ST_TIMEOUT = 3'd4;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_LEN_HI = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

/* hdl/crc_checked_command_frame_parser.sv */
// Top level: start-byte hunter, length-prefixed frame parser with CRC-16 check.
//
//  channel | direction | beat carries
//  in_     | sink      | cmd (byte or timer tick), rx_byte
//  out_    | source    | kind, data byte and index, or end-of-frame header and status
//  cfg_    | sink      | register index, write data (start byte, timeout limit)
//
// One beat per cycle sustained while out_ accepts: an input register, one pass of
// CRC and parse logic, then the result register.
// Reset (rst_n low, synchronous) empties both registers and returns to hunting.
// A stalled out_ holds the result; the input register stalls behind it.
module crc_checked_command_frame_parser
  import ccfp_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [7:0]        out_data_byte,
  output logic [DIDX_W-1:0] out_data_index,
  output logic [7:0]        out_opcode,
  output logic [7:0]        out_first_param,
  output logic [7:0]        out_second_param,
  output logic [15:0]       out_third_param,
  output logic [DIDX_W-1:0] out_data_length,
  output logic [ST_W-1:0]   out_status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata
);

  logic [7:0] start_byte_r;
  logic [7:0] timeout_r;

  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic [7:0] s1_byte_r;
  logic       s1_fire;

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       op_r, op_nxt;
  logic [7:0]       p1_r, p1_nxt;
  logic [7:0]       p2_r, p2_nxt;
  logic [15:0]      p3_r, p3_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;
  logic [7:0]       idle_r, idle_nxt;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [7:0]        out_byte_r;
  logic [DIDX_W-1:0] out_index_r;
  logic [7:0]        out_op_r;
  logic [7:0]        out_p1_r;
  logic [7:0]        out_p2_r;
  logic [15:0]       out_p3_r;
  logic [DIDX_W-1:0] out_dlen_r;
  logic [ST_W-1:0]   out_status_r;

  logic              res_valid;
  logic              res_kind;
  logic [7:0]        res_byte;
  logic [DIDX_W-1:0] res_index;
  logic [7:0]        res_op;
  logic [7:0]        res_p1;
  logic [7:0]        res_p2;
  logic [15:0]       res_p3;
  logic [DIDX_W-1:0] res_dlen;
  logic [ST_W-1:0]   res_status;

  logic             is_tick;
  logic             is_byte;
  logic [7:0]       idle_inc;
  logic [7:0]       lim;
  logic             timeout_hit;
  logic [LEN_W-1:0] len_full;
  logic             len_short;
  logic             len_long;
  logic [LEN_W-1:0] len_m2;
  logic             body_crc;
  logic             body_crc_lo;
  logic             body_end;
  logic [LEN_W-1:0] upto;
  logic [LEN_W-1:0] to_dlen;
  logic [LEN_W-1:0] ok_dlen;
  logic [LEN_W-1:0] data_pos;
  logic [15:0]      crc_upd;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= 8'h00;
      timeout_r    <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_BYTE: start_byte_r <= cfg_wdata;
        REG_TIMEOUT:    timeout_r    <= cfg_wdata;
        default:        start_byte_r <= start_byte_r;
      endcase
    end
  end

  // input register
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd_r  <= in_cmd;
      s1_byte_r <= in_rx_byte;
    end
  end

  // decisions
  always_comb begin
    is_tick     = (s1_cmd_r == CMD_TICK);
    is_byte     = (s1_cmd_r == CMD_BYTE);
    idle_inc    = (idle_r == TICK_MAX) ? idle_r : idle_r + 8'd1;
    lim         = (timeout_r == 8'd0) ? 8'd1 : timeout_r;
    timeout_hit = is_tick && (phase_r != PH_HUNT) && (idle_inc >= lim);
    len_full    = {s1_byte_r, len_r[7:0]};
    len_short   = is_byte && (phase_r == PH_LEN_HI) && (len_full < MIN_LEN);
    len_long    = is_byte && (phase_r == PH_LEN_HI) && !(len_full < MIN_LEN)
                  && (len_full > LEN_W'(MAX_FRAME));
    len_m2      = len_r - CRC_BYTES;
    body_crc    = is_byte && (phase_r == PH_BODY) && (cnt_r < len_m2);
    body_crc_lo = is_byte && (phase_r == PH_BODY) && (cnt_r == len_m2);
    body_end    = is_byte && (phase_r == PH_BODY) && (cnt_r > len_m2);
    upto        = (cnt_r > len_m2) ? len_m2 : cnt_r;
    to_dlen     = ((phase_r == PH_BODY) && (upto > POS_DATA)) ? upto - POS_DATA : '0;
    ok_dlen     = (len_r > OVERHEAD) ? len_r - OVERHEAD : '0;
    data_pos    = cnt_r - POS_DATA;
    crc_upd     = crc16_byte(crc_r, s1_byte_r);
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (timeout_hit || len_short || len_long || body_end) begin
      phase_nxt = PH_HUNT;
    end else if (is_byte) begin
      unique case (phase_r)
        PH_HUNT:   if (s1_byte_r == start_byte_r) phase_nxt = PH_LEN_LO;
        PH_LEN_LO: phase_nxt = PH_LEN_HI;
        PH_LEN_HI: phase_nxt = PH_BODY;
        PH_BODY:   phase_nxt = PH_BODY;
        default:   phase_nxt = PH_HUNT;
      endcase
    end
  end

  // frame state
  always_comb begin
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    op_nxt     = op_r;
    p1_nxt     = p1_r;
    p2_nxt     = p2_r;
    p3_nxt     = p3_r;
    crc_lo_nxt = crc_lo_r;
    idle_nxt   = idle_r;
    if (is_tick) begin
      if (phase_r != PH_HUNT) begin
        idle_nxt = idle_inc;
      end
    end else begin
      idle_nxt = 8'd0;
      unique case (phase_r)
        PH_HUNT: begin
          if (s1_byte_r == start_byte_r) begin
            len_nxt    = '0;
            cnt_nxt    = '0;
            crc_nxt    = CRC_INIT;
            op_nxt     = 8'h00;
            p1_nxt     = 8'h00;
            p2_nxt     = 8'h00;
            p3_nxt     = 16'h0000;
            crc_lo_nxt = 8'h00;
          end
        end
        PH_LEN_LO: begin
          len_nxt = {8'h00, s1_byte_r};
          crc_nxt = crc_upd;
          cnt_nxt = LEN_W'(1);
        end
        PH_LEN_HI: begin
          len_nxt = len_full;
          crc_nxt = crc_upd;
          cnt_nxt = LEN_W'(2);
        end
        PH_BODY: begin
          if (body_crc) begin
            crc_nxt = crc_upd;
            cnt_nxt = cnt_r + LEN_W'(1);
            if (cnt_r == POS_OPCODE) begin
              op_nxt = s1_byte_r;
            end else if (cnt_r == POS_P1) begin
              p1_nxt = s1_byte_r;
            end else if (cnt_r == POS_P2) begin
              p2_nxt = s1_byte_r;
            end else if (cnt_r == POS_P3_LO) begin
              if (len_r >= P3_MIN_LEN) p3_nxt = {8'h00, s1_byte_r};
            end else if (cnt_r == POS_P3_HI) begin
              p3_nxt = {s1_byte_r, p3_r[7:0]};
            end
          end else if (body_crc_lo) begin
            crc_lo_nxt = s1_byte_r;
            cnt_nxt    = cnt_r + LEN_W'(1);
          end
        end
        default: idle_nxt = 8'd0;
      endcase
    end
  end

  // result
  always_comb begin
    res_valid  = 1'b0;
    res_kind   = KIND_DATA;
    res_byte   = 8'h00;
    res_index  = '0;
    res_op     = 8'h00;
    res_p1     = 8'h00;
    res_p2     = 8'h00;
    res_p3     = 16'h0000;
    res_dlen   = '0;
    res_status = ST_OK;
    if (timeout_hit) begin
      res_valid  = 1'b1;
      res_kind   = KIND_END;
      res_op     = op_r;
      res_p1     = p1_r;
      res_p2     = p2_r;
      res_p3     = p3_r;
      res_dlen   = to_dlen[DIDX_W-1:0];
      res_status = ST_TIMEOUT;
    end else if (len_short || len_long) begin
      res_valid  = 1'b1;
      res_kind   = KIND_END;
      res_status = len_short ? ST_SHORT : ST_LONG;
    end else if (body_end) begin
      res_valid  = 1'b1;
      res_kind   = KIND_END;
      res_op     = op_r;
      res_p1     = p1_r;
      res_p2     = p2_r;
      res_p3     = p3_r;
      res_dlen   = ok_dlen[DIDX_W-1:0];
      res_status = ({s1_byte_r, crc_lo_r} == crc_r) ? ST_OK : ST_CRC_ERR;
    end else if (body_crc && (cnt_r >= POS_DATA)) begin
      res_valid = 1'b1;
      res_kind  = KIND_DATA;
      res_byte  = s1_byte_r;
      res_index = data_pos[DIDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      len_r    <= '0;
      cnt_r    <= '0;
      crc_r    <= CRC_INIT;
      op_r     <= 8'h00;
      p1_r     <= 8'h00;
      p2_r     <= 8'h00;
      p3_r     <= 16'h0000;
      crc_lo_r <= 8'h00;
      idle_r   <= 8'h00;
    end else if (s1_fire) begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      crc_r    <= crc_nxt;
      op_r     <= op_nxt;
      p1_r     <= p1_nxt;
      p2_r     <= p2_nxt;
      p3_r     <= p3_nxt;
      crc_lo_r <= crc_lo_nxt;
      idle_r   <= idle_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_kind_r   <= res_kind;
      out_byte_r   <= res_byte;
      out_index_r  <= res_index;
      out_op_r     <= res_op;
      out_p1_r     <= res_p1;
      out_p2_r     <= res_p2;
      out_p3_r     <= res_p3;
      out_dlen_r   <= res_dlen;
      out_status_r <= res_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_data_byte    = out_byte_r;
  assign out_data_index   = out_index_r;
  assign out_opcode       = out_op_r;
  assign out_first_param  = out_p1_r;
  assign out_second_param = out_p2_r;
  assign out_third_param  = out_p3_r;
  assign out_data_length  = out_dlen_r;
  assign out_status       = out_status_r;

  a_body_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (len_r >= MIN_LEN) && (len_r <= LEN_W'(MAX_FRAME)))
    else $error("frame body entered with out-of-range length");

  a_body_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (cnt_r < len_r) && (cnt_r >= POS_OPCODE))
    else $error("byte position outside the declared frame");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> s1_valid_r && $stable(s1_cmd_r) && $stable(s1_byte_r))
    else $error("stalled input register lost its beat");

  a_data_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_DATA)) |-> (out_status_r == ST_OK))
    else $error("data beat carries a nonzero status");

endmodule

/* dv/crc_checked_command_frame_parser_tb.sv */
// Self-checking testbench: directed and random byte/tick beats against a parser predictor.
module crc_checked_command_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ccfp_pkg::*;

  localparam int FRAME_MAX     = 1024;
  localparam int RAND_ITEMS    = 1550;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_MIN     = 100;
  localparam int MAX_WAIT      = 19;
  localparam int SETTLE_CYCLES = 4;
  localparam int STUCK_LIMIT   = 1000;
  localparam int N_DIRECTED    = 21;

  typedef struct packed {
    logic              kind;
    logic [7:0]        data_byte;
    logic [DIDX_W-1:0] data_index;
    logic [7:0]        opcode;
    logic [7:0]        first_param;
    logic [7:0]        second_param;
    logic [15:0]       third_param;
    logic [DIDX_W-1:0] data_length;
    logic [ST_W-1:0]   status;
  } frame_result_t;

  typedef enum logic [0:0] {
    ROW_BEAT = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    logic            sel;
    logic [7:0]      value;
    logic            typed;
    logic [ST_W-1:0] status;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_cmd = CMD_BYTE;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_kind;
  logic [7:0]        out_data_byte;
  logic [DIDX_W-1:0] out_data_index;
  logic [7:0]        out_opcode;
  logic [7:0]        out_first_param;
  logic [7:0]        out_second_param;
  logic [15:0]       out_third_param;
  logic [DIDX_W-1:0] out_data_length;
  logic [ST_W-1:0]   out_status;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = REG_START_BYTE;
  logic [7:0]        cfg_wdata = 8'h00;

  logic [7:0]  start_code = 8'h00;
  logic [7:0]  tick_limit = TIMEOUT_RST;
  phase_t      parse_phase = PH_HUNT;
  logic [15:0] frame_len = '0;
  logic [15:0] frame_pos = '0;
  logic [15:0] crc_acc = CRC_INIT;
  logic [7:0]  opcode_q = '0;
  logic [7:0]  p1_q = '0;
  logic [7:0]  p2_q = '0;
  logic [15:0] p3_q = '0;
  logic [7:0]  crc_lo_q = '0;
  logic [7:0]  idle_q = '0;

  frame_result_t expected_results[$];
  int mismatches = 0;
  int stuck_cycles = 0;
  int out_hold = 0;
  int counted_beats = 0;
  bit calm = 1'b0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_BEAT, CMD_TICK,       8'hFF, 1'b0, ST_OK},
    '{ROW_BEAT, CMD_BYTE,       8'h00, 1'b0, ST_OK},
    '{ROW_BEAT, CMD_BYTE,       8'h04, 1'b0, ST_OK},
    '{ROW_BEAT, CMD_BYTE,       8'h00, 1'b1, ST_SHORT},
    '{ROW_BEAT, CMD_BYTE,       8'h00, 1'b0, ST_OK},
    '{ROW_BEAT, CMD_BYTE,       8'hFF, 1'b0, ST_OK},
    '{ROW_BEAT, CMD_BYTE,       8'hFF, 1'b1, ST_LONG},
    '{ROW_BEAT, CMD_BYTE,       8'h00, 1'b0, ST_OK},
    '{ROW_BEAT, CMD_BYTE,       8'h08, 1'b0, ST_OK},
    '{ROW_BEAT, CMD_BYTE,       8'h00, 1'b0, ST_OK},
    '{ROW_BEAT, CMD_BYTE,       8'hA5, 1'b0, ST_OK},
    '{ROW_BEAT, CMD_BYTE,       8'h00, 1'b0, ST_OK},
    '{ROW_BEAT, CMD_BYTE,       8'hFF, 1'b0, ST_OK},
    '{ROW_BEAT, CMD_BYTE,       8'h3C, 1'b0, ST_OK},
    '{ROW_BEAT, CMD_BYTE,       8'h00, 1'b0, ST_OK},
    '{ROW_BEAT, CMD_BYTE,       8'h00, 1'b0, ST_OK},
    '{ROW_CFG,  REG_START_BYTE, 8'hFF, 1'b0, ST_OK},
    '{ROW_CFG,  REG_TIMEOUT,    8'h00, 1'b0, ST_OK},
    '{ROW_BEAT, CMD_BYTE,       8'hFF, 1'b0, ST_OK},
    '{ROW_BEAT, CMD_BYTE,       8'h07, 1'b0, ST_OK},
    '{ROW_BEAT, CMD_TICK,       8'h00, 1'b1, ST_TIMEOUT}
  };

  crc_checked_command_frame_parser #(
    .MAX_FRAME(FRAME_MAX)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_data_index   (out_data_index),
    .out_opcode       (out_opcode),
    .out_first_param  (out_first_param),
    .out_second_param (out_second_param),
    .out_third_param  (out_third_param),
    .out_data_length  (out_data_length),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic frame_result_t close_frame(input logic keep_header, input logic [15:0] dlen,
                                                input logic [ST_W-1:0] st);
    frame_result_t r;
    r = '0;
    r.kind = KIND_END;
    if (keep_header) begin
      r.opcode       = opcode_q;
      r.first_param  = p1_q;
      r.second_param = p2_q;
      r.third_param  = p3_q;
    end
    r.data_length = dlen[DIDX_W-1:0];
    r.status      = st;
    parse_phase   = PH_HUNT;
    return r;
  endfunction

  function automatic logic parse_beat(input logic cmd, input logic [7:0] b,
                                      output frame_result_t r);
    logic [7:0]  lim;
    logic [15:0] pos;
    logic [15:0] span;
    r = '0;
    pos = frame_pos;
    if (cmd == CMD_TICK) begin
      if (parse_phase == PH_HUNT) begin
        return 1'b0;
      end
      lim = (tick_limit == 8'd0) ? 8'd1 : tick_limit;
      if (idle_q != TICK_MAX) begin
        idle_q++;
      end
      if (idle_q < lim) begin
        return 1'b0;
      end
      span = 16'd0;
      if (parse_phase == PH_BODY) begin
        span = (pos > frame_len - CRC_BYTES) ? frame_len - CRC_BYTES : pos;
        span = (span > POS_DATA) ? span - POS_DATA : 16'd0;
      end
      r = close_frame(1'b1, span, ST_TIMEOUT);
      return 1'b1;
    end
    idle_q = '0;
    case (parse_phase)
      PH_HUNT: begin
        if (b == start_code) begin
          frame_len   = '0;
          frame_pos   = '0;
          crc_acc     = CRC_INIT;
          opcode_q    = '0;
          p1_q        = '0;
          p2_q        = '0;
          p3_q        = '0;
          crc_lo_q    = '0;
          parse_phase = PH_LEN_LO;
        end
        return 1'b0;
      end
      PH_LEN_LO: begin
        frame_len   = {8'h00, b};
        crc_acc     = crc16_step(crc_acc, b);
        frame_pos   = 16'd1;
        parse_phase = PH_LEN_HI;
        return 1'b0;
      end
      PH_LEN_HI: begin
        frame_len[15:8] = b;
        crc_acc         = crc16_step(crc_acc, b);
        frame_pos       = 16'd2;
        if (frame_len < MIN_LEN) begin
          r = close_frame(1'b0, 16'd0, ST_SHORT);
          return 1'b1;
        end
        if (frame_len > FRAME_MAX) begin
          r = close_frame(1'b0, 16'd0, ST_LONG);
          return 1'b1;
        end
        parse_phase = PH_BODY;
        return 1'b0;
      end
      default: ;
    endcase
    if (pos < frame_len - CRC_BYTES) begin
      crc_acc   = crc16_step(crc_acc, b);
      frame_pos = pos + 16'd1;
      case (pos)
        POS_OPCODE: opcode_q = b;
        POS_P1:     p1_q = b;
        POS_P2:     p2_q = b;
        POS_P3_LO: begin
          if (frame_len >= P3_MIN_LEN) begin
            p3_q = {8'h00, b};
          end
        end
        POS_P3_HI:  p3_q = p3_q | {b, 8'h00};
        default: begin
          r.kind       = KIND_DATA;
          r.data_byte  = b;
          r.data_index = DIDX_W'(pos - POS_DATA);
          return 1'b1;
        end
      endcase
      return 1'b0;
    end
    if (pos == frame_len - CRC_BYTES) begin
      crc_lo_q  = b;
      frame_pos = pos + 16'd1;
      return 1'b0;
    end
    r = close_frame(1'b1, (frame_len > OVERHEAD) ? frame_len - OVERHEAD : 16'd0,
                    ({b, crc_lo_q} == crc_acc) ? ST_OK : ST_CRC_ERR);
    return 1'b1;
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  function automatic int eff_limit();
    return (tick_limit == 8'd0) ? 1 : int'(tick_limit);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic compare_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  task automatic send_beat(input logic cmd, input logic [7:0] b, input logic typed = 1'b0,
                           input logic [ST_W-1:0] typed_status = ST_OK);
    int            gap;
    frame_result_t res;
    logic          has_res;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    counted_beats++;
    has_res = parse_beat(cmd, b, res);
    if (typed) begin
      res        = '0;
      res.kind   = KIND_END;
      res.status = typed_status;
    end
    if (typed || has_res) begin
      expected_results.push_back(res);
    end
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_beat(CMD_TICK, 8'($urandom));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_START_BYTE) begin
      start_code = val;
    end else begin
      tick_limit = val;
    end
  endtask

  task automatic apply_config(input logic [7:0] start_val, input logic [7:0] limit_val);
    settle();
    write_reg(REG_START_BYTE, start_val);
    write_reg(REG_TIMEOUT, limit_val);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input logic [15:0] len, input bit with_ticks = 1'b1);
    logic [7:0]  body[$];
    logic [15:0] crc;
    int          lim;
    body = {len[7:0], len[15:8]};
    repeat (len - 16'd4) body.push_back(8'($urandom));
    crc = CRC_INIT;
    foreach (body[i]) begin
      crc = crc16_step(crc, body[i]);
    end
    if ($urandom_range(0, 99) < 15) begin
      crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    end
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    send_beat(CMD_BYTE, start_code);
    lim = eff_limit();
    foreach (body[i]) begin
      if (with_ticks && $urandom_range(0, 99) < 4) begin
        if (lim > 1 && $urandom_range(0, 3) != 0) begin
          send_ticks($urandom_range(1, (lim - 1 < 5) ? lim - 1 : 5));
        end else begin
          send_ticks(lim);
        end
      end
      send_beat(CMD_BYTE, body[i]);
    end
  endtask

  task automatic send_unit();
    int          roll;
    int          depth;
    logic [15:0] len;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      if (parse_phase != PH_HUNT) begin
        send_ticks(eff_limit());
      end
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        len = 16'($urandom_range(5, 20));
      end else if (roll < 92) begin
        len = 16'($urandom_range(21, 60));
      end else begin
        len = 16'($urandom_range(61, 200));
      end
      send_frame(len);
    end else if (roll < 80) begin
      send_beat(CMD_BYTE, start_code);
      case ($urandom_range(0, 3))
        0: len = 16'($urandom_range(0, 4));
        1: len = 16'(FRAME_MAX + 1);
        2: len = 16'hFFFF;
        default: len = 16'($urandom_range(FRAME_MAX + 1, 16'hFFFF));
      endcase
      send_beat(CMD_BYTE, len[7:0]);
      send_beat(CMD_BYTE, len[15:8]);
    end else if (roll < 88) begin
      send_beat(CMD_BYTE, start_code);
      len = 16'($urandom_range(5, 40));
      depth = $urandom_range(0, len - 1);
      for (int i = 0; i < depth; i++) begin
        send_beat(CMD_BYTE, (i == 0) ? len[7:0] : (i == 1) ? len[15:8] : 8'($urandom));
      end
      send_ticks(eff_limit());
    end else begin
      repeat ($urandom_range(1, 8)) send_beat(1'($urandom_range(0, 1)), 8'($urandom));
    end
  endtask

  always @(posedge clk) begin : result_sink
    frame_result_t seen;
    frame_result_t want;
    int            hold;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold  <= 0;
    end else if (out_valid && out_ready) begin
      seen = {out_kind, out_data_byte, out_data_index, out_opcode, out_first_param,
              out_second_param, out_third_param, out_data_length, out_status};
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected, kind", 16'(seen.kind), 16'd0);
      end else begin
        want = expected_results.pop_front();
        compare_field("kind", 16'(seen.kind), 16'(want.kind));
        compare_field("data_byte", 16'(seen.data_byte), 16'(want.data_byte));
        compare_field("data_index", 16'(seen.data_index), 16'(want.data_index));
        compare_field("opcode", 16'(seen.opcode), 16'(want.opcode));
        compare_field("first_param", 16'(seen.first_param), 16'(want.first_param));
        compare_field("second_param", 16'(seen.second_param), 16'(want.second_param));
        compare_field("third_param", seen.third_param, want.third_param);
        compare_field("data_length", 16'(seen.data_length), 16'(want.data_length));
        compare_field("status", 16'(seen.status), 16'(want.status));
      end
      hold = draw_wait();
      out_ready <= (hold == 0);
      out_hold  <= hold;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      if (out_hold == 1) begin
        out_ready <= 1'b1;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int phase_base;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (i == 0 || directed_rows[i-1].kind != ROW_CFG) begin
          settle();
        end
        write_reg(directed_rows[i].sel, directed_rows[i].value);
        if (i == N_DIRECTED - 1 || directed_rows[i+1].kind != ROW_CFG) begin
          cfg_valid <= 1'b0;
        end
      end else begin
        send_beat(directed_rows[i].sel, directed_rows[i].value, directed_rows[i].typed,
                  directed_rows[i].status);
      end
    end

    counted_beats = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: apply_config(8'h7E, 8'd255);
        1: apply_config(8'h00, 8'd1);
        2: apply_config(8'hFF, 8'd0);
        3: apply_config(8'($urandom), 8'($urandom_range(2, 254)));
        4: apply_config(8'h5A, 8'd3);
        default: apply_config(8'($urandom), TIMEOUT_RST);
      endcase
      calm = (p == 1 || p == 4);
      phase_base = counted_beats;
      if (p == 0) begin
        send_frame(16'(FRAME_MAX), 1'b0);
      end
      while (counted_beats < (p + 1) * RAND_ITEMS / NUM_PHASES ||
             counted_beats - phase_base < PHASE_MIN) begin
        send_unit();
        if ($urandom_range(0, 99) < 3) begin
          settle();
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
